### rtl/core/chlm_pkg.sv
package chlm_pkg;

  localparam int MAX_LINES_DEF  = 64;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam int AGE_W  = 6;
  localparam int CNT_W  = 32;
  localparam int ADDR_W = 32;

  localparam logic [AGE_W-1:0] AGE_MAX = 6'd63;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LOG2   = 2'd2;

  localparam logic [1:0] ASSOC_MODE_RST  = 2'd0;
  localparam logic [4:0] OFFSET_BITS_RST = 5'd2;
  localparam logic [2:0] LINE_LOG2_RST   = 3'd6;

  localparam logic [4:0] OFFSET_MIN = 5'd2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ASSOC_DIRECT = 2'd0,
    ASSOC_FULL   = 2'd1,
    ASSOC_TWO    = 2'd2,
    ASSOC_FOUR   = 2'd3
  } assoc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_AGE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] read_hit_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] write_hit_count;
  } stats_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] read_hit_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] write_hit_count;
  } out_t;

  // status of one access as it retires into the counters
  typedef struct packed {
    logic upd;
    logic hit;
    logic is_write;
  } stat_upd_t;

endpackage

### rtl/core/chlm_store.sv
module chlm_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int TAG_W = 30
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [TAG_W-1:0]           rd_tag,
  output logic [chlm_pkg::AGE_W-1:0] rd_age,
  output logic                       rd_valid,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [TAG_W-1:0]           wr_tag,
  input  logic [chlm_pkg::AGE_W-1:0] wr_age,
  input  logic                       wr_set_valid
);

  localparam int WORD_W = TAG_W + chlm_pkg::AGE_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] word_r;
  logic [DEPTH-1:0]  valid_r;
  logic [DEPTH-1:0]  aged_r;
  logic              valid_q_r;
  logic              aged_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      aged_r  <= '0;
    end else if (wr_en) begin
      aged_r[wr_addr] <= 1'b1;
      if (wr_set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_age};
    end
    if (rd_en) begin
      word_r    <= mem[rd_addr];
      valid_q_r <= valid_r[rd_addr];
      aged_q_r  <= aged_r[rd_addr];
    end
  end

  // an age never written reads as zero
  assign rd_tag   = word_r[WORD_W-1:chlm_pkg::AGE_W];
  assign rd_age   = aged_q_r ? word_r[chlm_pkg::AGE_W-1:0] : '0;
  assign rd_valid = valid_q_r;

endmodule

### rtl/core/chlm_way_unit.sv
module chlm_way_unit #(
  parameter int TAG_W = 30
) (
  input  logic                       ent_valid,
  input  logic [TAG_W-1:0]           ent_tag,
  input  logic [chlm_pkg::AGE_W-1:0] ent_age,
  input  logic [TAG_W-1:0]           look_tag,
  input  logic [chlm_pkg::AGE_W-1:0] best_age,
  input  logic                       is_keep,
  output logic                       match,
  output logic                       older,
  output logic [chlm_pkg::AGE_W-1:0] new_age
);

  assign match = ent_valid && (ent_tag == look_tag);
  assign older = ent_age > best_age;

  always_comb begin
    if (is_keep) begin
      new_age = '0;
    end else if (ent_age < chlm_pkg::AGE_MAX) begin
      new_age = ent_age + chlm_pkg::AGE_W'(1);
    end else begin
      new_age = ent_age;
    end
  end

endmodule

### rtl/core/chlm_stats.sv
module chlm_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  chlm_pkg::stat_upd_t upd,
  output chlm_pkg::stats_t    stats
);

  chlm_pkg::stats_t cnt_r;
  chlm_pkg::stats_t cnt_nxt;

  localparam logic [chlm_pkg::CNT_W-1:0] ONE = 32'd1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (upd.upd) begin
      cnt_nxt.total_count = cnt_r.total_count + ONE;
      if (upd.is_write) begin
        cnt_nxt.write_count = cnt_r.write_count + ONE;
      end else begin
        cnt_nxt.read_count = cnt_r.read_count + ONE;
      end
      if (upd.hit) begin
        cnt_nxt.hit_count = cnt_r.hit_count + ONE;
        if (upd.is_write) begin
          cnt_nxt.write_hit_count = cnt_r.write_hit_count + ONE;
        end else begin
          cnt_nxt.read_hit_count = cnt_r.read_hit_count + ONE;
        end
      end else begin
        cnt_nxt.miss_count = cnt_r.miss_count + ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stats = cnt_r;

endmodule

### rtl/core/cache_hit_miss_lru_model.sv
// Channel  Ports                                  Direction  Payload
// in       in_valid, in_ready, in_data            input      in_t (opcode, address)
// out      out_valid, out_ready, out_data         output     out_t (hit, seven counters)
// cfg      cfg_valid, cfg_ready, cfg_index/data   input      register index, value
//
// An access goes from its in transfer through setup, a lookup pass and an aging pass
// over the W ways of its set (1, 2 or 4, or every line in use when fully associative)
// and a finish state to out_valid. The tag/age memory has one read port: one way is
// read per cycle in the lookup pass and again in the aging pass, the shared way unit
// checking each one. Reset is synchronous, active low; valid and age marks are
// flip-flops cleared at once, so no clearing pass follows reset. in_ready is high only
// while idle; a result waiting on out_ready holds the next access in its last cycle.
module cache_hit_miss_lru_model #(
  parameter int MAX_LINES  = chlm_pkg::MAX_LINES_DEF,
  parameter int ADDR_WIDTH = chlm_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  chlm_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output chlm_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chlm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FLOOR_LOG2 = $clog2(MAX_LINES + 1) - 1;
  localparam int LMAX       = (FLOOR_LOG2 < 7) ? FLOOR_LOG2 : 7;
  localparam int DEPTH      = 1 << LMAX;
  localparam int IDX_W      = LMAX;
  localparam int EFF_AW     = (ADDR_WIDTH < chlm_pkg::ADDR_W) ? ADDR_WIDTH : chlm_pkg::ADDR_W;
  localparam int TAG_W      = EFF_AW - 2;
  localparam logic [chlm_pkg::ADDR_W-1:0] ADDR_MASK =
    chlm_pkg::ADDR_W'((64'(1) << EFF_AW) - 64'(1));
  localparam logic [2:0] LMAX_L = 3'(LMAX);
  localparam logic [IDX_W:0] ISS_ONE = (IDX_W+1)'(1);

  // configuration
  logic [1:0] assoc_r;
  logic [4:0] off_r;
  logic [2:0] lc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assoc_r <= chlm_pkg::ASSOC_MODE_RST;
      off_r   <= chlm_pkg::OFFSET_BITS_RST;
      lc_r    <= chlm_pkg::LINE_LOG2_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        chlm_pkg::CFG_ASSOC_MODE:  assoc_r <= cfg_data[1:0];
        chlm_pkg::CFG_OFFSET_BITS: off_r   <= cfg_data;
        chlm_pkg::CFG_LINE_LOG2:   lc_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer state
  chlm_pkg::state_t state_r, state_nxt;
  chlm_pkg::in_t    req_r, req_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0] wm1_r, wm1_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [IDX_W:0]   iss_r, iss_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_w_r, chk_w_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hway_r, hway_nxt;
  logic [IDX_W-1:0] vic_r, vic_nxt;
  logic [chlm_pkg::AGE_W-1:0] best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;

  // geometry
  logic [2:0]                lines_log2;
  logic [2:0]                ways_log2;
  logic [2:0]                set_log2;
  logic [4:0]                off_eff;
  logic [chlm_pkg::ADDR_W-1:0] addr_m;
  logic [chlm_pkg::ADDR_W-1:0] addr_sh;
  logic [5:0]                tag_sh;
  logic [chlm_pkg::ADDR_W-1:0] tag_full;
  logic [IDX_W-1:0]          set_idx;

  always_comb begin
    lines_log2 = (lc_r > LMAX_L) ? LMAX_L : lc_r;
    case (chlm_pkg::assoc_t'(assoc_r))
      chlm_pkg::ASSOC_DIRECT: ways_log2 = 3'd0;
      chlm_pkg::ASSOC_FULL:   ways_log2 = lines_log2;
      chlm_pkg::ASSOC_TWO:    ways_log2 = 3'd1;
      chlm_pkg::ASSOC_FOUR:   ways_log2 = 3'd2;
      default:                ways_log2 = 3'd0;
    endcase
    if (ways_log2 > lines_log2) begin
      ways_log2 = lines_log2;
    end
    set_log2 = lines_log2 - ways_log2;
    off_eff  = (off_r < chlm_pkg::OFFSET_MIN) ? chlm_pkg::OFFSET_MIN : off_r;
    addr_m   = req_r.address & ADDR_MASK;
    addr_sh  = addr_m >> off_eff;
    tag_sh   = {1'b0, off_eff} + {3'b000, set_log2};
    tag_full = addr_m >> tag_sh;
    set_idx  = addr_sh[IDX_W-1:0] & ~({IDX_W{1'b1}} << set_log2);
  end

  // memory and shared unit
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [TAG_W-1:0]           rd_tag;
  logic [chlm_pkg::AGE_W-1:0] rd_age;
  logic                       rd_valid;
  logic                       wr_en;
  logic [TAG_W-1:0]           wr_tag;
  logic                       wr_set_valid;
  logic                       is_keep;
  logic                       u_match;
  logic                       u_older;
  logic [chlm_pkg::AGE_W-1:0] u_age;
  logic [IDX_W-1:0]           keep_w;
  logic                       last_chk;
  chlm_pkg::stat_upd_t        supd;
  chlm_pkg::stats_t           stats;

  chlm_store #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W),
    .TAG_W(TAG_W)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_tag       (rd_tag),
    .rd_age       (rd_age),
    .rd_valid     (rd_valid),
    .wr_en        (wr_en),
    .wr_addr      (base_r | chk_w_r),
    .wr_tag       (wr_tag),
    .wr_age       (u_age),
    .wr_set_valid (wr_set_valid)
  );

  chlm_way_unit #(
    .TAG_W(TAG_W)
  ) u_way (
    .ent_valid (rd_valid),
    .ent_tag   (rd_tag),
    .ent_age   (rd_age),
    .look_tag  (tag_r),
    .best_age  (best_r),
    .is_keep   (is_keep),
    .match     (u_match),
    .older     (u_older),
    .new_age   (u_age)
  );

  chlm_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (supd),
    .stats (stats)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    base_nxt      = base_r;
    wm1_nxt       = wm1_r;
    tag_nxt       = tag_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = 1'b0;
    chk_w_nxt     = iss_r[IDX_W-1:0];
    hit_nxt       = hit_r;
    hway_nxt      = hway_r;
    vic_nxt       = vic_r;
    best_nxt      = best_r;
    out_hit_nxt   = out_hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = base_r | iss_r[IDX_W-1:0];
    wr_en         = 1'b0;
    keep_w        = hit_r ? hway_r : vic_r;
    is_keep       = (chk_w_r == keep_w);
    wr_tag        = (is_keep && !hit_r) ? tag_r : rd_tag;
    wr_set_valid  = is_keep && !hit_r;
    last_chk      = chk_v_r && (chk_w_r == wm1_r);
    supd          = '0;

    case (state_r)
      chlm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = chlm_pkg::ST_SETUP;
        end
      end
      chlm_pkg::ST_SETUP: begin
        base_nxt  = set_idx << ways_log2;
        wm1_nxt   = ~({IDX_W{1'b1}} << ways_log2);
        tag_nxt   = tag_full[TAG_W-1:0];
        iss_nxt   = '0;
        hit_nxt   = 1'b0;
        hway_nxt  = '0;
        vic_nxt   = '0;
        best_nxt  = '0;
        state_nxt = chlm_pkg::ST_SCAN;
      end
      chlm_pkg::ST_SCAN: begin
        rd_en     = (iss_r <= {1'b0, wm1_r});
        chk_v_nxt = rd_en;
        if (rd_en) begin
          iss_nxt = iss_r + ISS_ONE;
        end
        if (chk_v_r) begin
          if (u_match && !hit_r) begin
            hit_nxt  = 1'b1;
            hway_nxt = chk_w_r;
          end
          // strictly older wins, so a tie keeps the lower way
          if (chk_w_r == '0 || u_older) begin
            vic_nxt  = chk_w_r;
            best_nxt = rd_age;
          end
        end
        if (last_chk) begin
          iss_nxt   = '0;
          chk_v_nxt = 1'b0;
          state_nxt = chlm_pkg::ST_AGE;
        end
      end
      chlm_pkg::ST_AGE: begin
        // read way k while writing back way k-1
        rd_en     = (iss_r <= {1'b0, wm1_r});
        chk_v_nxt = rd_en;
        if (rd_en) begin
          iss_nxt = iss_r + ISS_ONE;
        end
        wr_en = chk_v_r;
        if (last_chk) begin
          chk_v_nxt = 1'b0;
          state_nxt = chlm_pkg::ST_FIN;
        end
      end
      chlm_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          supd.upd      = 1'b1;
          supd.hit      = hit_r;
          supd.is_write = (req_r.opcode == chlm_pkg::OP_WRITE);
          out_hit_nxt   = hit_r;
          out_valid_nxt = 1'b1;
          state_nxt     = chlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chlm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chlm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    base_r    <= base_nxt;
    wm1_r     <= wm1_nxt;
    tag_r     <= tag_nxt;
    iss_r     <= iss_nxt;
    chk_w_r   <= chk_w_nxt;
    hit_r     <= hit_nxt;
    hway_r    <= hway_nxt;
    vic_r     <= vic_nxt;
    best_r    <= best_nxt;
    out_hit_r <= out_hit_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_data.hit             = out_hit_r;
  assign out_data.total_count     = stats.total_count;
  assign out_data.hit_count       = stats.hit_count;
  assign out_data.miss_count      = stats.miss_count;
  assign out_data.read_count      = stats.read_count;
  assign out_data.read_hit_count  = stats.read_hit_count;
  assign out_data.write_count     = stats.write_count;
  assign out_data.write_hit_count = stats.write_hit_count;

endmodule

### tb/sv/tb_cache_hit_miss_lru_model.sv
`timescale 1ns / 1ps

module tb_cache_hit_miss_lru_model;

  localparam int CLK_PERIOD  = 8;
  localparam int LINES       = chlm_pkg::MAX_LINES_DEF;
  localparam int IDLE_PCT    = 19;
  localparam int DRAIN_WAIT  = 2 * LINES + 16;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PRINT_LIMIT = 40;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  chlm_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  chlm_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [chlm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [chlm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // mirror of the cache geometry and tag store
  chlm_pkg::assoc_t geo_mode;
  logic [4:0]       geo_off;
  logic [2:0]       geo_lines;
  logic             line_valid [LINES];
  logic [63:0]      line_tag   [LINES];
  logic [5:0]       line_age   [LINES];
  chlm_pkg::stats_t stats_model;
  chlm_pkg::out_t   pending_results [$];

  bit no_idle = 1'b0;
  int error_count = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int geometries_run = 0;
  int cycle_count = 0;

  cache_hit_miss_lru_model u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void clear_cache_state();
    geo_mode  = chlm_pkg::assoc_t'(chlm_pkg::ASSOC_MODE_RST);
    geo_off   = chlm_pkg::OFFSET_BITS_RST;
    geo_lines = chlm_pkg::LINE_LOG2_RST;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_age[i]   = '0;
    end
    stats_model = '0;
  endfunction

  // look up one access, update tags, ages and counters, return the result
  function automatic chlm_pkg::out_t cache_lookup(input logic op, input logic [31:0] addr);
    int lines_lg, ways_lg, set_lg, off, ways, base, victim, hit_way, keep;
    logic [63:0] set_idx, tag;
    logic hit;
    lines_lg = geo_lines;
    while (lines_lg > 0 && (1 << lines_lg) > LINES) lines_lg--;
    case (geo_mode)
      chlm_pkg::ASSOC_DIRECT: ways_lg = 0;
      chlm_pkg::ASSOC_FULL:   ways_lg = lines_lg;
      chlm_pkg::ASSOC_TWO:    ways_lg = 1;
      default:                ways_lg = 2;
    endcase
    if (ways_lg > lines_lg) ways_lg = lines_lg;
    set_lg = lines_lg - ways_lg;
    ways   = 1 << ways_lg;
    off    = (geo_off < chlm_pkg::OFFSET_MIN) ? chlm_pkg::OFFSET_MIN : geo_off;
    set_idx = ({32'd0, addr} >> off) & ((64'd1 << set_lg) - 64'd1);
    tag     = {32'd0, addr} >> (off + set_lg);
    base    = int'(set_idx) * ways;

    hit = 1'b0;
    hit_way = 0;
    for (int w = 0; w < ways; w++) begin
      if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
        hit = 1'b1;
        hit_way = w;
      end
    end

    stats_model.total_count += 1;
    if (op == chlm_pkg::OP_WRITE) stats_model.write_count += 1;
    else stats_model.read_count += 1;

    if (hit) begin
      stats_model.hit_count += 1;
      if (op == chlm_pkg::OP_WRITE) stats_model.write_hit_count += 1;
      else stats_model.read_hit_count += 1;
      keep = hit_way;
    end else begin
      stats_model.miss_count += 1;
      // oldest line goes, lowest way on a tie
      victim = 0;
      for (int w = 1; w < ways; w++) begin
        if (line_age[base + w] > line_age[base + victim]) victim = w;
      end
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = tag;
      keep = victim;
    end

    for (int w = 0; w < ways; w++) begin
      if (w == keep) line_age[base + w] = '0;
      else if (line_age[base + w] < chlm_pkg::AGE_MAX) line_age[base + w] += 1;
    end
    return {hit, stats_model};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got 0x%08h, expected 0x%08h",
               $time, results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    chlm_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, total_count",
                        out_data.total_count, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(out_data.hit), 32'(want.hit));
        check_field("total_count", out_data.total_count, want.total_count);
        check_field("hit_count", out_data.hit_count, want.hit_count);
        check_field("miss_count", out_data.miss_count, want.miss_count);
        check_field("read_count", out_data.read_count, want.read_count);
        check_field("read_hit_count", out_data.read_hit_count, want.read_hit_count);
        check_field("write_count", out_data.write_count, want.write_count);
        check_field("write_hit_count", out_data.write_hit_count, want.write_hit_count);
      end
      results_seen++;
      if (out_data.hit) hits_seen++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // valid stays high after a transfer until the next item or a drain lowers it
  task automatic issue_access(input logic op, input logic [31:0] addr);
    chlm_pkg::in_t item;
    item.opcode  = op;
    item.address = addr;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(cache_lookup(op, addr));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [chlm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [chlm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      chlm_pkg::CFG_ASSOC_MODE:  geo_mode  = chlm_pkg::assoc_t'(val[1:0]);
      chlm_pkg::CFG_OFFSET_BITS: geo_off   = val;
      chlm_pkg::CFG_LINE_LOG2:   geo_lines = val[2:0];
      default: ;
    endcase
  endtask

  // reprogram only once the cache is idle; stored lines survive
  task automatic program_geometry(input chlm_pkg::assoc_t mode, input logic [4:0] off,
                                  input logic [2:0] lines_lg);
    wait_drained();
    write_register(chlm_pkg::CFG_ASSOC_MODE, 5'(mode));
    write_register(chlm_pkg::CFG_OFFSET_BITS, off);
    write_register(chlm_pkg::CFG_LINE_LOG2, 5'(lines_lg));
    cfg_valid <= 1'b0;
    geometries_run++;
  endtask

  // mostly revisit a small working set, with fresh random addresses mixed in
  task automatic run_traffic(input int count);
    logic [31:0] pool [16];
    logic [31:0] addr, blk_mask;
    int pool_n, off_eff;
    off_eff  = (geo_off < chlm_pkg::OFFSET_MIN) ? chlm_pkg::OFFSET_MIN : geo_off;
    blk_mask = (32'd1 << off_eff) - 32'd1;
    pool_n   = $urandom_range(2, 16);
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        addr = pool[$urandom_range(0, pool_n - 1)] ^ ($urandom & blk_mask);
      end else begin
        addr = $urandom;
        if ($urandom_range(0, 3) == 0) pool[$urandom_range(0, pool_n - 1)] = addr;
      end
      issue_access($urandom_range(0, 1) ? chlm_pkg::OP_WRITE : chlm_pkg::OP_READ, addr);
    end
  endtask

  task automatic test_default_geometry();
    issue_access(chlm_pkg::OP_READ, 32'h0000_0000);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_0000);
    issue_access(chlm_pkg::OP_READ, 32'hFFFF_FFFF);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_0100);
    issue_access(chlm_pkg::OP_READ, 32'h0000_0000);
  endtask

  task automatic test_geometry_corners();
    // line count above the store, offset below the minimum
    program_geometry(chlm_pkg::ASSOC_FULL, 5'd0, 3'd7);
    issue_access(chlm_pkg::OP_READ, 32'h0000_0000);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_0004);
    issue_access(chlm_pkg::OP_READ, 32'hFFFF_FFFC);
    // four ways asked with a single line
    program_geometry(chlm_pkg::ASSOC_FOUR, 5'd1, 3'd0);
    issue_access(chlm_pkg::OP_READ, 32'h8000_0000);
    issue_access(chlm_pkg::OP_READ, 32'h8000_0000);
    issue_access(chlm_pkg::OP_WRITE, 32'h4000_0000);
    // offset wider than the useful address
    program_geometry(chlm_pkg::ASSOC_TWO, 5'd31, 3'd1);
    issue_access(chlm_pkg::OP_READ, 32'h8000_0000);
    issue_access(chlm_pkg::OP_READ, 32'h0000_0000);
    issue_access(chlm_pkg::OP_WRITE, 32'hFFFF_FFFF);
    program_geometry(chlm_pkg::ASSOC_DIRECT, 5'd16, 3'd6);
    issue_access(chlm_pkg::OP_READ, 32'hFFFF_0000);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_FFFF);
  endtask

  task automatic test_lru_order();
    program_geometry(chlm_pkg::ASSOC_FOUR, 5'd2, 3'd2);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_1000);
    issue_access(chlm_pkg::OP_READ, 32'h0000_2000);
    issue_access(chlm_pkg::OP_READ, 32'h0000_3000);
    issue_access(chlm_pkg::OP_WRITE, 32'h0000_4000);
    issue_access(chlm_pkg::OP_READ, 32'h0000_1000);
    issue_access(chlm_pkg::OP_READ, 32'h0000_5000);
  endtask

  task automatic test_random_sweep();
    program_geometry(chlm_pkg::ASSOC_DIRECT, 5'd2, 3'd0);
    run_traffic(115);
    program_geometry(chlm_pkg::ASSOC_FULL, 5'd2, 3'd6);
    run_traffic(115);
    program_geometry(chlm_pkg::ASSOC_FOUR, 5'd16, 3'd6);
    run_traffic(115);
    program_geometry(chlm_pkg::ASSOC_TWO, 5'd31, 3'd7);
    run_traffic(115);
    program_geometry(chlm_pkg::ASSOC_FULL, 5'd1, 3'd3);
    run_traffic(115);
    program_geometry(chlm_pkg::ASSOC_DIRECT, 5'd16, 3'd6);
    run_traffic(115);
    for (int p = 0; p < 8; p++) begin
      program_geometry(chlm_pkg::assoc_t'(2'($urandom_range(0, 3))),
                       ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(2, 16)),
                       3'($urandom_range(0, 7)));
      run_traffic(115);
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    program_geometry(chlm_pkg::ASSOC_TWO, 5'd4, 3'd5);
    run_traffic(200);
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    clear_cache_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_geometry();
    test_geometry_corners();
    test_lru_order();
    test_random_sweep();
    test_back_to_back();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d lookups (%0d hits) over %0d geometries", results_seen,
             hits_seen, geometries_run);
    $display("all mapping modes, offsets 0..31 and line counts 1..64 with capping");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
